// ===== rtl/tbg_pkg.sv =====
package tbg_pkg;

	// Sequencer states of the step engine.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ,
		ST_CHECK,
		ST_SQRT,
		ST_GM,
		ST_M3,
		ST_FORCE,
		ST_KA,
		ST_KB,
		ST_UNIT,
		ST_ACC,
		ST_DV,
		ST_DP,
		ST_DONE
	} state_t;

	// Opcodes of an input beat.
	localparam logic OP_STEP = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_MASS_A = 2'd0;
	localparam logic [1:0] REG_MASS_B = 2'd1;
	localparam logic [1:0] REG_TIME_STEP = 2'd2;
	localparam logic [1:0] REG_GRAVITY = 2'd3;

	// Axis codes; the code above the z axis selects nothing.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic signed [65:0] S32_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] S32_MIN = -66'sh0_8000_0000;

	// Clamp an unsigned intermediate to 32 bits.
	function automatic logic [31:0] cap32(input logic [63:0] v);
		cap32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Saturate a wide signed sum to the 32 bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > S32_MAX) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// ===== rtl/tbg_div.sv =====
module tbg_div #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] numer,
	input  logic [63:0] denom,
	output logic        done,
	output logic [31:0] quot
);
	import tbg_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [63:0]   rem_q;
	logic [63:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [64:0]   trial;
	logic          fits;

	// One restoring step per cycle; quotient bits shift into the dividend register.
	assign trial = {rem_q, dvd_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {numer, {FRACTION_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= denom;
		end else if (run_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			dvd_q <= {dvd_q[NW-2:0], fits};
		end
	end

	// A zero divisor gives an all-ones quotient, which the cap turns into the maximum.
	assign done = done_q;
	assign quot = cap32(64'(dvd_q));

endmodule

// ===== rtl/tbg_isqrt.sv =====
module tbg_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	import tbg_pkg::*;

	logic [63:0] x_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] trem;
	logic [35:0] trial;
	logic        fits;

	// Digit by digit square root, two radicand bits per cycle.
	assign trem  = {rem_q[33:0], x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = trem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rem_q  <= fits ? (trem - trial) : trem;
			root_q <= {root_q[30:0], fits};
			x_q    <= {x_q[61:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/two_body_gravity_euler_step_core.sv =====
// Load beat: from acceptance the sequencer goes straight to ST_DONE, which fills the result beat.
// Step beat: its work is six serial divisions, a square root and 23 multiplies on the
// shared multiplier; when the bodies coincide, the square root, the divisions and the
// acceleration multiplies are skipped.
// One beat is in work at a time; the next is taken once the result sits in the output register.
// Reset is asynchronous, active low; it restores the configuration and control registers and both bodies' state.
module two_body_gravity_euler_step_core #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic               body_select,
	input  logic [1:0]         axis_select,
	input  logic signed [31:0] load_position,
	input  logic signed [31:0] load_velocity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_a_x,
	output logic signed [31:0] pos_a_y,
	output logic signed [31:0] pos_a_z,
	output logic signed [31:0] pos_b_x,
	output logic signed [31:0] pos_b_y,
	output logic signed [31:0] pos_b_z,
	output logic               coincident
);
	import tbg_pkg::*;

	localparam logic [30:0] MASS_RST = 31'(64'd10 << FRACTION_BITS);
	localparam logic [30:0] DT_RST = 31'((64'd1 << FRACTION_BITS) / 60);
	localparam logic [30:0] G_RST = 31'(((64'd7 << FRACTION_BITS) + 64'd50) / 100);
	localparam logic [31:0] POS_B_X_RST = 32'(64'd10 << FRACTION_BITS);

	state_t state_q, state_d;

	logic [30:0] mass_a_q, mass_b_q, dt_q, grav_q;
	logic signed [31:0] pos_q [2][3];
	logic signed [31:0] vel_q [2][3];
	logic [1:0] ax_q;
	logic       bd_q;
	logic       ph_q;
	logic       flag_q;
	logic       out_valid_q;

	logic signed [31:0] d_q [3];
	logic [63:0] s_q;
	logic [31:0] dist_q, gm_q, m3_q, force_q;
	logic [31:0] k_q [2];
	logic [FRACTION_BITS:0] u_q [3];
	logic [31:0] accm_q [2][3];
	logic        accn_q [2][3];
	logic [63:0] prod_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] psh;
	logic [31:0] dmag [3];
	logic signed [31:0] cur_v, cur_p;
	logic [31:0] vmag;
	logic        div_start, div_done, sqrt_start, sqrt_done;
	logic [31:0] div_n, div_q, sqrt_root;
	logic [63:0] div_d;
	logic        ax_last, six_last, adv, accept, out_free;
	logic signed [65:0] dv_delta, dp_delta, vsum, psum;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ax_last  = ax_q == AXIS_Z;
	assign six_last = ax_last && bd_q;
	assign psh      = prod_q >> FRACTION_BITS;
	assign cur_v    = vel_q[bd_q][ax_q];
	assign cur_p    = pos_q[bd_q][ax_q];
	assign vmag     = cur_v[31] ? (~cur_v + 32'd1) : cur_v;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_q[i][31] ? (~d_q[i] + 32'd1) : d_q[i];
		end
	end

	// Signed updates of velocity and position, products taken on magnitudes.
	assign dv_delta = accn_q[bd_q][ax_q] ? -$signed({2'b00, psh}) : $signed({2'b00, psh});
	assign dp_delta = cur_v[31] ? -$signed({2'b00, psh}) : $signed({2'b00, psh});
	assign vsum = 66'(cur_v) + dv_delta;
	assign psum = 66'(cur_p) + dp_delta;

	tbg_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(div_n),
		.denom(div_d), .done(div_done), .quot(div_q)
	);

	tbg_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .x(s_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = (opcode == OP_LOAD) ? ST_DONE : ST_DIFF;
			ST_DIFF:  state_d = ST_SQ;
			ST_SQ:    if (ph_q && ax_last) state_d = ST_CHECK;
			ST_CHECK: state_d = (s_q == 64'd0) ? ST_DV : ST_SQRT;
			ST_SQRT:  if (ph_q && sqrt_done) state_d = ST_GM;
			ST_GM:    if (ph_q) state_d = ST_M3;
			ST_M3:    if (ph_q) state_d = ST_FORCE;
			ST_FORCE: if (ph_q && div_done) state_d = ST_KA;
			ST_KA:    if (ph_q && div_done) state_d = ST_KB;
			ST_KB:    if (ph_q && div_done) state_d = ST_UNIT;
			ST_UNIT:  if (ph_q && div_done && ax_last) state_d = ST_ACC;
			ST_ACC:   if (ph_q && six_last) state_d = ST_DV;
			ST_DV:    if (ph_q && six_last) state_d = ST_DP;
			ST_DP:    if (ph_q && six_last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Unit controls and operand selection.
	always_comb begin
		in_ready   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		div_n      = '0;
		div_d      = '0;
		sqrt_start = 1'b0;
		adv        = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SQ: begin
				mul_a = dmag[ax_q];
				mul_b = dmag[ax_q];
				adv   = ph_q;
			end
			ST_SQRT: sqrt_start = !ph_q;
			ST_GM: begin
				mul_a = {1'b0, grav_q};
				mul_b = {1'b0, mass_a_q};
			end
			ST_M3: begin
				mul_a = gm_q;
				mul_b = {1'b0, mass_b_q};
			end
			ST_FORCE: begin
				div_start = !ph_q;
				div_n     = m3_q;
				div_d     = s_q >> FRACTION_BITS;
			end
			ST_KA: begin
				div_start = !ph_q;
				div_n     = force_q;
				div_d     = {33'd0, mass_a_q};
			end
			ST_KB: begin
				div_start = !ph_q;
				div_n     = force_q;
				div_d     = {33'd0, mass_b_q};
			end
			ST_UNIT: begin
				div_start = !ph_q;
				div_n     = dmag[ax_q];
				div_d     = {32'd0, dist_q};
				adv       = ph_q && div_done;
			end
			ST_ACC: begin
				mul_a = k_q[bd_q];
				mul_b = 32'(u_q[ax_q]);
				adv   = ph_q;
			end
			ST_DV: begin
				mul_a = accm_q[bd_q][ax_q];
				mul_b = {1'b0, dt_q};
				adv   = ph_q;
			end
			ST_DP: begin
				mul_a = vmag;
				mul_b = {1'b0, dt_q};
				adv   = ph_q;
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Control, configuration and body state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mass_a_q    <= MASS_RST;
			mass_b_q    <= MASS_RST;
			dt_q        <= DT_RST;
			grav_q      <= G_RST;
			ax_q        <= AXIS_X;
			bd_q        <= 1'b0;
			ph_q        <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < 2; b++) begin
				for (int i = 0; i < 3; i++) begin
					pos_q[b][i] <= '0;
					vel_q[b][i] <= '0;
				end
			end
			pos_q[1][0] <= POS_B_X_RST;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_MASS_A:    mass_a_q <= cfg_wdata;
					REG_MASS_B:    mass_b_q <= cfg_wdata;
					REG_TIME_STEP: dt_q <= cfg_wdata;
					REG_GRAVITY:   grav_q <= cfg_wdata;
					default: begin
					end
				endcase
			end

			// Phase bit: multiply states alternate, unit states wait for done.
			case (state_q)
				ST_SQ, ST_GM, ST_M3, ST_ACC, ST_DV, ST_DP: ph_q <= !ph_q;
				ST_FORCE, ST_KA, ST_KB, ST_UNIT: ph_q <= ph_q ? !div_done : 1'b1;
				ST_SQRT: ph_q <= ph_q ? !sqrt_done : 1'b1;
				default: ph_q <= 1'b0;
			endcase

			// Axis and body counters walk the per-component loops.
			if (adv) begin
				if (ax_last) begin
					ax_q <= AXIS_X;
					if (state_q == ST_ACC || state_q == ST_DV || state_q == ST_DP) begin
						bd_q <= !bd_q;
					end
				end else begin
					ax_q <= ax_q + 2'd1;
				end
			end

			if (accept) begin
				flag_q <= 1'b0;
				if (opcode == OP_LOAD && axis_select <= AXIS_Z) begin
					pos_q[body_select][axis_select] <= load_position;
					vel_q[body_select][axis_select] <= load_velocity;
				end
			end

			if (state_q == ST_CHECK && s_q == 64'd0) begin
				flag_q <= 1'b1;
			end
			if (state_q == ST_DV && ph_q) begin
				vel_q[bd_q][ax_q] <= sat32(vsum);
			end
			if (state_q == ST_DP && ph_q) begin
				pos_q[bd_q][ax_q] <= sat32(psum);
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Intermediate values of a step.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= '0;
			for (int b = 0; b < 2; b++) begin
				for (int i = 0; i < 3; i++) begin
					accm_q[b][i] <= '0;
					accn_q[b][i] <= 1'b0;
				end
			end
		end
		if (state_q == ST_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= sat32(66'(pos_q[0][i]) - 66'(pos_q[1][i]));
			end
		end
		if (state_q == ST_SQ && ph_q) begin
			s_q <= s_q + prod_q;
		end
		if (state_q == ST_SQRT && sqrt_done) begin
			dist_q <= sqrt_root;
		end
		if (state_q == ST_GM && ph_q) begin
			gm_q <= cap32(psh);
		end
		if (state_q == ST_M3 && ph_q) begin
			m3_q <= cap32(psh);
		end
		if (ph_q && div_done) begin
			if (state_q == ST_FORCE) force_q <= div_q;
			if (state_q == ST_KA) k_q[0] <= div_q;
			if (state_q == ST_KB) k_q[1] <= div_q;
			if (state_q == ST_UNIT) u_q[ax_q] <= div_q[FRACTION_BITS:0];
		end
		// Body A accelerates against the difference, body B along it.
		if (state_q == ST_ACC && ph_q) begin
			accm_q[bd_q][ax_q] <= psh[31:0];
			accn_q[bd_q][ax_q] <= bd_q ? d_q[ax_q][31] :
				(!d_q[ax_q][31] && (d_q[ax_q] != 32'sd0));
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			pos_a_x    <= pos_q[0][0];
			pos_a_y    <= pos_q[0][1];
			pos_a_z    <= pos_q[0][2];
			pos_b_x    <= pos_q[1][0];
			pos_b_y    <= pos_q[1][1];
			pos_b_z    <= pos_q[1][2];
			coincident <= flag_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== test/two_body_gravity_euler_step_core_tb.sv =====
module two_body_gravity_euler_step_core_tb;
	import tbg_pkg::*;

	typedef struct packed {
		logic        op;
		logic        body;
		logic [1:0]  axis;
		logic [31:0] pos;
		logic [31:0] vel;
	} beat_t;

	typedef struct packed {
		logic [31:0] ax, ay, az, bx, by, bz;
		logic        flag;
	} snapshot_t;

	localparam int FB = 16;
	localparam logic [63:0] CAP = 64'hFFFF_FFFF;
	localparam int STALL_LIMIT = 20000;
	localparam int N_PHASES = 7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = REG_MASS_A;
	logic [30:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               opcode = OP_STEP;
	logic               body_select = 1'b0;
	logic [1:0]         axis_select = AXIS_X;
	logic signed [31:0] load_position = '0;
	logic signed [31:0] load_velocity = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z;
	logic               coincident;

	two_body_gravity_euler_step_core DUT (.*);

	// Shadow of the block's registers and body state.
	logic [63:0] mass_a_q, mass_b_q, dt_q, grav_q;
	longint pos_a[3], pos_b[3], vel_a[3], vel_b[3];

	beat_t     pending[$];
	snapshot_t expected_positions[$];
	int        errors = 0;
	int        stall_cycles = 0;
	int        in_idle = 0;
	int        out_idle = 0;
	bit        in_taken = 0;
	bit        quiet = 0;

	function automatic longint clamp32(input longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = (a * b) >> FB;
		return p > CAP ? CAP : p;
	endfunction

	function automatic logic [63:0] qdiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		if (d == 0) return CAP;
		q = (n << FB) / d;
		return q > CAP ? CAP : q;
	endfunction

	// Product with a Q.F scale, rounded toward zero.
	function automatic longint scale_toward_zero(input longint v, input logic [63:0] m);
		logic [63:0] p;
		p = (magnitude(v) * m) >> FB;
		return v < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Apply one accepted beat to the shadow state and return the positions it yields.
	function automatic snapshot_t advance_bodies(input beat_t b);
		snapshot_t r;
		longint d[3], acc_a[3], acc_b[3];
		logic [63:0] s, root_len, r2, force_q, ka, kb, u, m;
		r.flag = 1'b0;
		if (b.op == OP_LOAD) begin
			if (b.axis <= AXIS_Z) begin
				if (b.body) begin
					pos_b[b.axis] = longint'(signed'(b.pos));
					vel_b[b.axis] = longint'(signed'(b.vel));
				end else begin
					pos_a[b.axis] = longint'(signed'(b.pos));
					vel_a[b.axis] = longint'(signed'(b.vel));
				end
			end
		end else begin
			s = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = clamp32(pos_a[i] - pos_b[i]);
				m = magnitude(d[i]);
				s += m * m;
				acc_a[i] = 0;
				acc_b[i] = 0;
			end
			if (s == 0) begin
				r.flag = 1'b1;
			end else begin
				root_len = int_sqrt(s);
				r2 = s >> FB;
				force_q = qdiv(qmul(qmul(grav_q, mass_a_q), mass_b_q), r2);
				ka = qdiv(force_q, mass_a_q);
				kb = qdiv(force_q, mass_b_q);
				for (int i = 0; i < 3; i++) begin
					u = (magnitude(d[i]) << FB) / root_len;
					if (d[i] > 0) begin
						acc_a[i] = -longint'((ka * u) >> FB);
						acc_b[i] = longint'((kb * u) >> FB);
					end else if (d[i] < 0) begin
						acc_a[i] = longint'((ka * u) >> FB);
						acc_b[i] = -longint'((kb * u) >> FB);
					end
				end
			end
			// Semi-implicit Euler: velocity first, then position from the new velocity.
			for (int i = 0; i < 3; i++) begin
				vel_a[i] = clamp32(vel_a[i] + scale_toward_zero(acc_a[i], dt_q));
				vel_b[i] = clamp32(vel_b[i] + scale_toward_zero(acc_b[i], dt_q));
				pos_a[i] = clamp32(pos_a[i] + scale_toward_zero(vel_a[i], dt_q));
				pos_b[i] = clamp32(pos_b[i] + scale_toward_zero(vel_b[i], dt_q));
			end
		end
		r.ax = pos_a[0][31:0];
		r.ay = pos_a[1][31:0];
		r.az = pos_a[2][31:0];
		r.bx = pos_b[0][31:0];
		r.by = pos_b[1][31:0];
		r.bz = pos_b[2][31:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	// Clock and reset.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	// Input driver: holds a beat until it is taken, with random idle bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 0;
				if (in_idle > 0) begin
					in_idle--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					in_idle = $urandom_range(1, 9) - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					in_valid <= 1'b1;
					opcode <= pending[0].op;
					body_select <= pending[0].body;
					axis_select <= pending[0].axis;
					load_position <= pending[0].pos;
					load_velocity <= pending[0].vel;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// Output back pressure in bursts.
			if (out_idle > 0) begin
				out_idle--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_idle = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on input beats, checks result beats, runs the watchdog.
	always @(posedge clk) begin
		snapshot_t want;
		if (arst_n) begin
			stall_cycles++;
			if (in_valid && in_ready) begin
				expected_positions.push_back(advance_bodies(pending.pop_front()));
				in_taken = 1;
				stall_cycles = 0;
			end
			if (out_valid && out_ready) begin
				stall_cycles = 0;
				if (expected_positions.size() == 0) begin
					$error("result beat with no expectation waiting");
					errors++;
				end else begin
					want = expected_positions.pop_front();
					check_field("pos_a_x", want.ax, pos_a_x);
					check_field("pos_a_y", want.ay, pos_a_y);
					check_field("pos_a_z", want.az, pos_a_z);
					check_field("pos_b_x", want.bx, pos_b_x);
					check_field("pos_b_y", want.by, pos_b_y);
					check_field("pos_b_z", want.bz, pos_b_z);
					check_field("coincident", {31'd0, want.flag}, {31'd0, coincident});
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic beat_t load_beat(input logic body, input logic [1:0] axis,
			input logic [31:0] p, input logic [31:0] v);
		beat_t b;
		b.op = OP_LOAD;
		b.body = body;
		b.axis = axis;
		b.pos = p;
		b.vel = v;
		return b;
	endfunction

	function automatic beat_t step_beat();
		beat_t b;
		b = load_beat(1'b0, AXIS_X, $urandom, $urandom);
		b.op = OP_STEP;
		return b;
	endfunction

	// Signed value within +/- span whole units, random fraction.
	function automatic logic [31:0] moderate(input int span);
		return $urandom_range(0, 2 * span * 65536) - span * 65536;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MASS_A: mass_a_q = value;
			REG_MASS_B: mass_b_q = value;
			REG_TIME_STEP: dt_q = value;
			default: grav_q = value;
		endcase
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_positions.size() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Stimulus: directed beats, then per register setting a run of random scenes and noise beats.
	initial begin
		logic [30:0] cfg_sets[N_PHASES][4];
		int count;
		int span;
		mass_a_q = 655360;
		mass_b_q = 655360;
		dt_q = 1092;
		grav_q = 4588;
		for (int i = 0; i < 3; i++) begin
			pos_a[i] = 0;
			pos_b[i] = 0;
			vel_a[i] = 0;
			vel_b[i] = 0;
		end
		pos_b[0] = 64'sd10 << FB;
		cfg_sets[0] = '{31'd655360, 31'd655360, 31'd1092, 31'd4588};
		cfg_sets[1] = '{31'd1, 31'h7FFF_FFFF, 31'd1092, 31'd4588};
		cfg_sets[2] = '{31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
		cfg_sets[3] = '{31'd655360, 31'd655360, 31'd0, 31'd0};
		cfg_sets[4] = '{31'd196608, 31'd458752, 31'd65536, 31'd65536};
		cfg_sets[5] = '{31'd1, 31'd1, 31'd1092, 31'h7FFF_FFFF};
		cfg_sets[6] = '{31'd655360, 31'd655360, 31'd4369, 31'd4588};
		@(posedge arst_n);

		// Directed: step from reset, field extremes, unused axis, coincidence, tiny distance.
		pending.push_back(step_beat());
		pending.push_back(load_beat(1'b0, AXIS_X, 32'h7FFF_FFFF, 32'h8000_0000));
		pending.push_back(load_beat(1'b1, AXIS_X, 32'h8000_0000, 32'h7FFF_FFFF));
		pending.push_back(step_beat());
		pending.push_back(load_beat(1'b1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (int a = 0; a < 3; a++) begin
			pending.push_back(load_beat(1'b0, a[1:0], 32'h0001_8000, 32'd0));
			pending.push_back(load_beat(1'b1, a[1:0], 32'h0001_8000, 32'd0));
		end
		pending.push_back(step_beat());
		pending.push_back(load_beat(1'b1, AXIS_Z, 32'h0001_8001, 32'hFFFF_FFFF));
		pending.push_back(step_beat());
		pending.push_back(step_beat());
		pending.push_back(load_beat(1'b1, AXIS_Z, 32'h0003_0000, 32'h0000_0001));
		pending.push_back(step_beat());
		pending.push_back(step_beat());
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			quiet = (ph == N_PHASES - 1);
			write_reg(REG_MASS_A, cfg_sets[ph][0]);
			write_reg(REG_MASS_B, cfg_sets[ph][1]);
			write_reg(REG_TIME_STEP, cfg_sets[ph][2]);
			write_reg(REG_GRAVITY, cfg_sets[ph][3]);
			count = 0;
			while (count < 180) begin
				if ($urandom_range(0, 6) == 0) begin
					// Noise: any field value, either operation.
					pending.push_back(load_beat(1'($urandom), 2'($urandom), $urandom,
						$urandom));
					pending[$].op = 1'($urandom);
					count++;
				end else begin
					// A scene: place both bodies, then let them move.
					span = $urandom_range(0, 3) == 0 ? 2 : 60;
					for (int a = 0; a < 3; a++) begin
						pending.push_back(load_beat(1'b0, a[1:0], moderate(span), moderate(3)));
						pending.push_back(load_beat(1'b1, a[1:0], moderate(span), moderate(3)));
					end
					count += 6;
					for (int k = $urandom_range(2, 8); k > 0; k--) begin
						pending.push_back(step_beat());
						count++;
					end
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
